[rtl/btp_pkg.sv]
package btp_pkg;

	typedef logic [20:0] cp_t;

	// input word: one raw byte of UTF-8 text
	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_word_t;

	// output word: one kept code point or the end-of-text marker
	typedef struct packed {
		logic        item_kind;
		logic [20:0] code_point;
		logic [16:0] span_start;
		logic [16:0] span_end;
		logic        new_word;
		logic        run_last;
	} out_word_t;

	// what the classifier says about one decoded code point
	typedef struct packed {
		logic keep;     // emit it
		logic brk;      // close the open word after it
		logic solo;     // force a word start
		cp_t  cp;       // folded and optionally lowercased value
	} cls_t;

	localparam int  CFG_IDX_W    = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWERCASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CJK_SPLIT = 1'd1;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam cp_t CP_BAD = 21'h00FFFD;

endpackage

[rtl/bert_text_pretokenizer.sv]
// Channel | Dir | Handshake           | Word
// --------+-----+---------------------+-------------------------------------------
// in      | in  | in_valid / in_ready   | btp_pkg::in_word_t  (text byte, last flag)
// out     | out | out_valid / out_ready | btp_pkg::out_word_t (code point or marker)
// cfg     | in  | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One byte enters per cycle while in_ready is high. It is registered (s1), decoded and classified in one pass,
// and its whole group of results (zero to three) lands in the result bank (s2); the first
// result is valid once the byte has moved from s1 into the bank and waits there until it is taken.
// A byte that yields more than one result holds the input side while the bank
// drains one word per cycle that out_ready is high; the bank reloads in the cycle its last word is taken.
// Reset clears control state and the decoder state at once; no clearing pass.
// A stall on out backs up into s1 and then drops in_ready; nothing is lost.
module bert_text_pretokenizer #(
	parameter longint unsigned MAX_TEXT_BYTES = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  btp_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output btp_pkg::out_word_t                  out_data,
	input  logic                                cfg_we,
	input  logic [btp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic                                cfg_wdata
);

	// position counters are wide enough to hold the saturation value itself
	localparam int POS_W = $clog2(MAX_TEXT_BYTES + 1);
	localparam logic [POS_W:0]   MAX_EXT = (POS_W + 1)'(MAX_TEXT_BYTES);
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT_BYTES);

	function automatic logic [POS_W-1:0] sat_add(logic [POS_W-1:0] b, logic [2:0] k);
		logic [POS_W:0] s;
		s = {1'b0, b} + (POS_W + 1)'(k);
		return (s > MAX_EXT) ? MAX_POS : s[POS_W-1:0];
	endfunction

	// sequence length from the lead byte; zero for continuation and 0xF8..0xFF
	function automatic logic [2:0] lead_len(logic [7:0] b);
		if (!b[7])             return 3'd1;
		if (b[7:5] == 3'b110)  return 3'd2;
		if (b[7:4] == 4'b1110) return 3'd3;
		if (b[7:3] == 5'b11110) return 3'd4;
		return 3'd0;
	endfunction

	// continuation bytes contribute their low six bits, unchecked
	function automatic btp_pkg::cp_t decode_seq(logic [31:0] w, logic [2:0] len);
		btp_pkg::cp_t c;
		case (len)
			3'd1:    c = {13'd0, w[7:0]};
			3'd2:    c = {10'd0, w[4:0], w[13:8]};
			3'd3:    c = {5'd0, w[3:0], w[13:8], w[21:16]};
			default: c = {w[2:0], w[13:8], w[21:16], w[29:24]};
		endcase
		return c;
	endfunction

	// configuration
	logic lc_q;
	logic cjk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q  <= 1'b1;
			cjk_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				btp_pkg::REG_LOWERCASE: lc_q  <= cfg_wdata;
				btp_pkg::REG_CJK_SPLIT: cjk_q <= cfg_wdata;
			endcase
		end
	end

	// input register
	btp_pkg::in_word_t in_s1;
	logic              v_s1;
	logic              adv;

	// result bank
	btp_pkg::out_word_t res_s2 [3];
	logic [1:0]         cnt_s2;
	logic [1:0]         rd_q;
	logic               last;
	logic               s2_free;

	// decoder state
	logic [7:0]       pend_q [3];
	logic [1:0]       pcnt_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] lead_q;
	logic             inw_q;

	assign out_valid = rd_q < cnt_s2;
	assign last      = (rd_q + 2'd1) == cnt_s2;
	assign s2_free   = !out_valid || (out_ready && last);
	assign adv       = v_s1 && s2_free;
	assign in_ready  = !v_s1 || adv;

	// --- decode pass: walk the pending bytes plus the new one ---
	logic [31:0]       bufv;
	logic [2:0]        n;
	logic [POS_W-1:0]  base;
	logic [POS_W-1:0]  satpos [5];
	logic              att_v [3];
	btp_pkg::cp_t      att_cp [3];
	logic [POS_W-1:0]  att_s [3];
	logic [POS_W-1:0]  att_e [3];
	logic [7:0]        npend [3];
	logic [1:0]        npcnt;
	logic [POS_W-1:0]  nlead;
	logic [2:0]        p;
	logic [2:0]        len;
	logic [2:0]        use_n;
	logic              stop;
	logic [31:0]       win;

	always_comb begin
		bufv = '0;
		for (int k = 0; k < 3; k++) begin
			if (k < int'(pcnt_q))
				bufv[8*k +: 8] = pend_q[k];
		end
		bufv[{pcnt_q, 3'b000} +: 8] = in_s1.text_byte;
		n    = {1'b0, pcnt_q} + 3'd1;
		base = (pcnt_q != 2'd0) ? lead_q : pos_q;
		for (int k = 0; k < 5; k++)
			satpos[k] = sat_add(base, 3'(k));

		p     = 3'd0;
		stop  = 1'b0;
		npcnt = 2'd0;
		nlead = lead_q;
		len   = 3'd0;
		use_n = 3'd0;
		win   = '0;
		for (int k = 0; k < 3; k++) begin
			npend[k]  = 8'd0;
			att_v[k]  = 1'b0;
			att_cp[k] = '0;
			att_s[k]  = '0;
			att_e[k]  = '0;
		end
		// at most three attempts: a cut-short sequence never exceeds three bytes
		for (int i = 0; i < 3; i++) begin
			if (!stop && p < n) begin
				win = bufv >> {p, 3'b000};
				len = lead_len(win[7:0]);
				if (len == 3'd0 || ({1'b0, p} + {1'b0, len}) > {1'b0, n}) begin
					if (len != 3'd0 && !in_s1.final_byte) begin
						// hold the unfinished sequence for the next byte
						stop  = 1'b1;
						npcnt = 2'(n - p);
						nlead = satpos[p];
						for (int k = 0; k < 3; k++)
							npend[k] = win[8*k +: 8];
					end else begin
						att_v[i]  = 1'b1;
						att_cp[i] = btp_pkg::CP_BAD;
						use_n     = 3'd1;
					end
				end else begin
					att_v[i]  = 1'b1;
					att_cp[i] = decode_seq(win, len);
					use_n     = len;
				end
				if (!stop) begin
					att_s[i] = satpos[p];
					att_e[i] = satpos[3'(p + use_n)];
					p        = p + use_n;
				end
			end
		end
	end

	// --- classify each attempt in parallel ---
	btp_pkg::cls_t cls [3];

	for (genvar g = 0; g < 3; g++) begin : g_cls
		btp_classify u_cls (
			.raw    (att_cp[g]),
			.lc_en  (lc_q),
			.cjk_en (cjk_q),
			.cls    (cls[g])
		);
	end

	// --- word tracking and packing of the result group ---
	btp_pkg::out_word_t gen_res [3];
	logic [1:0]         gen_cnt;
	logic               inw;
	logic [POS_W-1:0]   pos_n;

	always_comb begin
		inw     = inw_q;
		gen_cnt = 2'd0;
		pos_n   = sat_add(pos_q, 3'd1);
		for (int k = 0; k < 3; k++)
			gen_res[k] = '0;
		for (int i = 0; i < 3; i++) begin
			if (att_v[i]) begin
				if (cls[i].keep && gen_cnt != 2'd3) begin
					gen_res[gen_cnt].item_kind  = btp_pkg::KIND_CHAR;
					gen_res[gen_cnt].code_point = cls[i].cp;
					gen_res[gen_cnt].span_start = 17'(att_s[i]);
					gen_res[gen_cnt].span_end   = 17'(att_e[i]);
					gen_res[gen_cnt].new_word   = cls[i].solo || !inw;
					gen_cnt = gen_cnt + 2'd1;
				end
				if (cls[i].brk)
					inw = 1'b0;
				else if (cls[i].keep)
					inw = 1'b1;
			end
		end
		// end marker carries the text length in both span fields
		if (in_s1.final_byte && gen_cnt != 2'd3) begin
			gen_res[gen_cnt].item_kind  = btp_pkg::KIND_END;
			gen_res[gen_cnt].span_start = 17'(pos_n);
			gen_res[gen_cnt].span_end   = 17'(pos_n);
			gen_cnt = gen_cnt + 2'd1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			cnt_s2 <= 2'd0;
			rd_q   <= 2'd0;
			pcnt_q <= 2'd0;
			pos_q  <= '0;
			lead_q <= '0;
			inw_q  <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;

			if (adv) begin
				cnt_s2 <= gen_cnt;
				rd_q   <= 2'd0;
				// the last byte of a text resets the decoder for the next one
				if (in_s1.final_byte) begin
					pcnt_q <= 2'd0;
					pos_q  <= '0;
					lead_q <= '0;
					inw_q  <= 1'b0;
				end else begin
					pcnt_q <= npcnt;
					pos_q  <= pos_n;
					lead_q <= nlead;
					inw_q  <= inw;
				end
			end else if (out_valid && out_ready) begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			in_s1 <= in_data;
		if (adv) begin
			res_s2 <= gen_res;
			pend_q <= npend;
		end
	end

	always_comb begin
		case (rd_q)
			2'd1:    out_data = res_s2[1];
			2'd2:    out_data = res_s2[2];
			default: out_data = res_s2[0];
		endcase
		out_data.run_last = last;
	end

endmodule

[rtl/btp_classify.sv]
module btp_classify (
	input  btp_pkg::cp_t  raw,
	input  logic          lc_en,
	input  logic          cjk_en,
	output btp_pkg::cls_t cls
);

	function automatic btp_pkg::cp_t fold_wide(btp_pkg::cp_t c);
		btp_pkg::cp_t r;
		r = c;
		case (c) inside
			[21'h00FF10:21'h00FF19], [21'h00FF21:21'h00FF3A], [21'h00FF41:21'h00FF5A],
			21'h00FF05, 21'h00FF0F, 21'h00FF5E, 21'h00FF08, 21'h00FF09, 21'h00FF0C,
			21'h00FF0E, 21'h00FF1A, 21'h00FF1B, 21'h00FF1F, 21'h00FF01,
			21'h00FF0D: r = c - 21'h00FEE0;
			21'h003000: r = 21'h000020;
			default:    r = c;
		endcase
		return r;
	endfunction

	function automatic logic is_space(btp_pkg::cp_t c);
		return c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D ||
			c == 21'hA0 || (c >= 21'h2000 && c <= 21'h200A) ||
			c == 21'h202F || c == 21'h205F || c == 21'h3000;
	endfunction

	function automatic logic is_ctrl(btp_pkg::cp_t c);
		if (c == 21'h09 || c == 21'h0A || c == 21'h0D)
			return 1'b0;
		return c < 21'h20 || (c >= 21'h7F && c <= 21'h9F);
	endfunction

	function automatic logic is_punct(btp_pkg::cp_t c);
		return (c >= 21'd33 && c <= 21'd47) || (c >= 21'd58 && c <= 21'd64) ||
			(c >= 21'd91 && c <= 21'd96) || (c >= 21'd123 && c <= 21'd126) ||
			c == 21'hB7 || c == 21'hD7 || c == 21'hF7 || c == 21'hA1 ||
			c == 21'hBF || c == 21'hAB || c == 21'hBB || c == 21'hAC ||
			c == 21'hB1 || c == 21'hA7 || c == 21'hB6 ||
			(c >= 21'h2000 && c <= 21'h206F) || (c >= 21'h3000 && c <= 21'h303F) ||
			(c >= 21'hFF01 && c <= 21'hFF0F) || (c >= 21'hFF1A && c <= 21'hFF20) ||
			(c >= 21'hFF3B && c <= 21'hFF40) || (c >= 21'hFF5B && c <= 21'hFF65) ||
			(c >= 21'h2200 && c <= 21'h22FF) || (c >= 21'h25A0 && c <= 21'h26FF);
	endfunction

	function automatic logic is_cjk(btp_pkg::cp_t c);
		return (c >= 21'h4E00 && c <= 21'h9FFF) || (c >= 21'h3400 && c <= 21'h4DBF) ||
			(c >= 21'h20000 && c <= 21'h2A6DF) || (c >= 21'h2A700 && c <= 21'h2CEAF) ||
			(c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'h2F800 && c <= 21'h2FA1F);
	endfunction

	function automatic btp_pkg::cp_t lower_cp(btp_pkg::cp_t c);
		if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'hC0 && c <= 21'hD6) ||
			(c >= 21'hD8 && c <= 21'hDE))
			return c + 21'd32;
		if (c >= 21'h100 && c <= 21'h12E && !c[0])
			return c + 21'd1;
		return c;
	endfunction

	btp_pkg::cp_t f_cp;
	btp_pkg::cp_t l_cp;
	logic         drop;

	assign f_cp = fold_wide(raw);
	assign l_cp = lc_en ? lower_cp(f_cp) : f_cp;
	assign drop = f_cp == 21'd0 || f_cp == btp_pkg::CP_BAD || is_ctrl(f_cp);

	always_comb begin
		cls.cp = l_cp;
		if (drop) begin
			cls.keep = 1'b0;
			cls.brk  = 1'b0;
			cls.solo = 1'b0;
		end else if (is_space(f_cp)) begin
			cls.keep = 1'b0;
			cls.brk  = 1'b1;
			cls.solo = 1'b0;
		end else if ((cjk_en && is_cjk(f_cp)) || is_punct(l_cp)) begin
			cls.keep = 1'b1;
			cls.brk  = 1'b1;
			cls.solo = 1'b1;
		end else begin
			cls.keep = 1'b1;
			cls.brk  = 1'b0;
			cls.solo = 1'b0;
		end
	end

endmodule

[rtl/btp_check.sv]
module btp_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input btp_pkg::out_word_t            out_data
);

	// an output word appears only after a byte was taken
	a_out_from_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output word without an accepted byte two cycles earlier");

	// with nothing waiting on the output the input side is open
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output is empty");

	// end marker closes the byte's group and carries a zero-width span
	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.item_kind == btp_pkg::KIND_END) |->
		(out_data.run_last && out_data.code_point == 21'd0 && !out_data.new_word &&
		out_data.span_start == out_data.span_end))
		else $error("malformed end marker");

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("output word changed while stalled");

endmodule

bind bert_text_pretokenizer btp_check u_btp_check (.*);
